// File: hdl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the command frame parser and hex decoder.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int MAX_FRAME = 1024;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int ID_W      = 19;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHAR_START = 8'h40;  // '@'
    localparam logic [7:0] CHAR_END   = 8'h23;  // '#'
    localparam logic [7:0] CHAR_SEP   = 8'h3B;  // ';'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [23:0] CMD_ADD_CHARS = 24'h414444;
    localparam logic [23:0] CMD_DEL_CHARS = 24'h44454C;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;

    localparam logic RES_BYTE    = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    localparam logic [POS_W-1:0] POS_CMD_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CMD_LAST  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ID_THOU   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ID_HUND   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_ID_TENS   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_ID_ONES   = POS_W'(8);
    localparam logic [POS_W-1:0] POS_PAYLOAD   = POS_W'(9);
    localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(MAX_FRAME);

    // one queue entry: up to one byte result and one summary result
    typedef struct packed {
        logic            byte_v;
        logic [7:0]      data_byte;
        logic            sum_v;
        logic [1:0]      command_code;
        logic [ID_W-1:0] frame_id;
        logic            frame_valid;
        logic            payload_present;
    } t_work;

    // {ok, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// File: hdl/cfp_front.sv
// ----------------------------------------------------------------------------
// cfp_front
// Takes characters, tracks frame state and builds byte/summary work entries.
// ----------------------------------------------------------------------------
module cfp_front
    import cfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_frame,
    input  logic        i_q_full,
    output logic        o_q_wr,
    output t_work       o_q_data
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [23:0]      r_cmd, n_cmd;
    logic [ID_W-1:0]  r_id, n_id;
    logic             r_start, n_start;
    logic             r_end, n_end;
    logic             r_sep, n_sep;
    logic [3:0]       r_hi, n_hi;
    logic             r_hi_ok, n_hi_ok;

    logic             accept;
    logic             act;
    logic [4:0]       hex;
    logic [ID_W-1:0]  digit;
    logic [ID_W-1:0]  weight;
    logic             in_id;
    logic             pair_done;
    logic [7:0]       byte_val;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign act    = r_pos < POS_LIMIT;
    assign hex    = hex_decode(i_char_code);
    assign digit  = {{(ID_W-8){1'b0}}, i_char_code} - {{(ID_W-8){1'b0}}, CHAR_ZERO};
    assign in_id  = act && r_pos >= POS_ID_THOU && r_pos <= POS_ID_ONES;
    assign pair_done = act && r_pos >= POS_PAYLOAD && !r_pos[0];

    always_comb begin
        case (r_pos)
            POS_ID_THOU: weight = ID_W'(1000);
            POS_ID_HUND: weight = ID_W'(100);
            POS_ID_TENS: weight = ID_W'(10);
            default:     weight = ID_W'(1);
        endcase
    end

    always_comb begin
        if (!r_hi_ok) begin
            byte_val = 8'd0;
        end else if (!hex[4]) begin
            byte_val = {4'd0, r_hi};
        end else begin
            byte_val = {r_hi, hex[3:0]};
        end
    end

    always_comb begin
        n_pos   = act ? r_pos + POS_W'(1) : r_pos;
        n_cmd   = r_cmd;
        n_id    = r_id;
        n_start = r_start | (act && i_char_code == CHAR_START);
        n_end   = r_end | (act && i_char_code == CHAR_END);
        n_sep   = r_sep | (act && i_char_code == CHAR_SEP && r_pos >= POS_PAYLOAD);
        n_hi    = r_hi;
        n_hi_ok = r_hi_ok;
        if (act && r_pos >= POS_CMD_FIRST && r_pos <= POS_CMD_LAST) begin
            case (r_pos[1:0])
                2'd1:    n_cmd[23:16] = i_char_code;
                2'd2:    n_cmd[15:8]  = i_char_code;
                default: n_cmd[7:0]   = i_char_code;
            endcase
        end
        if (in_id) begin
            n_id = r_id + ID_W'(digit * weight);
        end
        if (act && r_pos >= POS_PAYLOAD) begin
            if (r_pos[0]) begin
                n_hi    = hex[3:0];
                n_hi_ok = hex[4];
            end else begin
                n_hi    = 4'd0;
                n_hi_ok = 1'b0;
            end
        end
    end

    always_comb begin
        o_q_data.byte_v          = pair_done;
        o_q_data.data_byte       = byte_val;
        o_q_data.sum_v           = i_end_of_frame;
        o_q_data.command_code    = (n_cmd == CMD_ADD_CHARS) ? CMD_ADD :
                                   (n_cmd == CMD_DEL_CHARS) ? CMD_DEL : CMD_NONE;
        o_q_data.frame_id        = n_id;
        o_q_data.frame_valid     = n_start && n_end;
        o_q_data.payload_present = n_sep;
    end

    assign o_q_wr = accept && (pair_done || i_end_of_frame);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end_of_frame)) begin
            r_pos   <= '0;
            r_cmd   <= '0;
            r_id    <= '0;
            r_start <= 1'b0;
            r_end   <= 1'b0;
            r_sep   <= 1'b0;
            r_hi    <= '0;
            r_hi_ok <= 1'b0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_cmd   <= n_cmd;
            r_id    <= n_id;
            r_start <= n_start;
            r_end   <= n_end;
            r_sep   <= n_sep;
            r_hi    <= n_hi;
            r_hi_ok <= n_hi_ok;
        end
    end

endmodule

// File: hdl/cfp_queue.sv
// ----------------------------------------------------------------------------
// cfp_queue
// Short first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module cfp_queue
    import cfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_work i_wr_data,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_empty,
    output t_work o_rd_data
);

    t_work            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_CW-1:0]  r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full    = r_cnt == Q_CW'(Q_DEPTH);
    assign o_empty   = r_cnt == '0;
    assign o_rd_data = r_mem[r_rp];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (rd_en) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/cfp_back.sv
// ----------------------------------------------------------------------------
// cfp_back
// Expands work entries into byte and summary results in an output register.
// ----------------------------------------------------------------------------
module cfp_back
    import cfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_work                  i_q_data,
    output logic                   o_q_rd,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic                   o_result_type,
    output logic [7:0]             o_data_byte,
    output logic [1:0]             o_command_code,
    output logic signed [ID_W-1:0] o_frame_id,
    output logic                   o_frame_valid,
    output logic                   o_payload_present,
    output logic                   o_last
);

    logic            r_ov;
    logic            r_byte_done;
    logic            r_type;
    logic [7:0]      r_byte;
    logic [1:0]      r_cmd;
    logic [ID_W-1:0] r_id;
    logic            r_valid;
    logic            r_pay;
    logic            r_last;

    logic            load;
    logic            emit_byte;

    assign load      = !i_q_empty && (!r_ov || i_pop);
    assign emit_byte = i_q_data.byte_v && !r_byte_done;
    assign o_q_rd    = load && !(emit_byte && i_q_data.sum_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov        <= 1'b0;
            r_byte_done <= 1'b0;
        end else begin
            if (load) begin
                r_ov        <= 1'b1;
                r_byte_done <= emit_byte && i_q_data.sum_v;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_byte) begin
                r_type  <= RES_BYTE;
                r_byte  <= i_q_data.data_byte;
                r_cmd   <= CMD_NONE;
                r_id    <= '0;
                r_valid <= 1'b0;
                r_pay   <= 1'b0;
                r_last  <= !i_q_data.sum_v;
            end else begin
                r_type  <= RES_SUMMARY;
                r_byte  <= 8'd0;
                r_cmd   <= i_q_data.command_code;
                r_id    <= i_q_data.frame_id;
                r_valid <= i_q_data.frame_valid;
                r_pay   <= i_q_data.payload_present;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_empty           = !r_ov;
    assign o_result_type     = r_type;
    assign o_data_byte       = r_byte;
    assign o_command_code    = r_cmd;
    assign o_frame_id        = $signed(r_id);
    assign o_frame_valid     = r_valid;
    assign o_payload_present = r_pay;
    assign o_last            = r_last;

endmodule

// File: hdl/command_frame_parser_hex_decoder.sv
// ----------------------------------------------------------------------------
// command_frame_parser_hex_decoder
// Text command frame parser with hex payload decoder, queue interfaces.
// ----------------------------------------------------------------------------
// One character is taken per cycle whenever full is low. The front end
// updates the frame state in the same cycle and posts a work entry to a
// four-entry queue when a hex pair completes or the frame ends; the back
// end delivers one result per cycle from its output register while pop is
// high and work is queued. A pair completed with the end of the frame yields
// byte then summary, holding the result side for both; other items yield one.
// ----------------------------------------------------------------------------
module command_frame_parser_hex_decoder
    import cfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_char_code,
    input  logic                   i_end_of_frame,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_result_type,
    output logic [7:0]             o_data_byte,
    output logic [1:0]             o_command_code,
    output logic signed [ID_W-1:0] o_frame_id,
    output logic                   o_frame_valid,
    output logic                   o_payload_present,
    output logic                   o_last
);

    logic  q_wr;
    t_work q_wr_data;
    logic  q_full;
    logic  q_rd;
    logic  q_empty;
    t_work q_rd_data;

    cfp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_char_code    (i_char_code),
        .i_end_of_frame (i_end_of_frame),
        .i_q_full       (q_full),
        .o_q_wr         (q_wr),
        .o_q_data       (q_wr_data)
    );

    cfp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_empty   (q_empty),
        .o_rd_data (q_rd_data)
    );

    cfp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_q_data          (q_rd_data),
        .o_q_rd            (q_rd),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_result_type     (o_result_type),
        .o_data_byte       (o_data_byte),
        .o_command_code    (o_command_code),
        .o_frame_id        (o_frame_id),
        .o_frame_valid     (o_frame_valid),
        .o_payload_present (o_payload_present),
        .o_last            (o_last)
    );

    // a byte that is not last is always followed at once by its summary
    a_summary_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> (!empty && o_result_type == RES_SUMMARY))
        else $error("summary did not follow its byte");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_type == RES_SUMMARY) |-> (o_last && o_data_byte == 8'd0))
        else $error("summary not last or carries a byte");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_type == RES_BYTE) |->
        (o_command_code == CMD_NONE && o_frame_id == '0 && !o_frame_valid
         && !o_payload_present))
        else $error("byte result carries summary fields");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_wr)
        else $error("queue written while full");

endmodule

// File: sim/tb_command_frame_parser_hex_decoder.sv
// ----------------------------------------------------------------------------
// tb_command_frame_parser_hex_decoder
// Self-checking bench for the command frame parser. A short set of directed
// frames is followed by random well-formed, truncated and noise frames, plus
// one frame that runs past the maximum length. Every accepted character is
// run through a local frame parser and every result transfer is checked
// against the oldest predicted result. Both handshakes idle at random in
// phases, and the receiver is held off once long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_command_frame_parser_hex_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import cfp_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
    } t_frame_char;

    typedef struct packed {
        logic            is_summary;
        logic [7:0]      data_byte;
        logic [1:0]      command_code;
        logic [ID_W-1:0] frame_id;
        logic            frame_valid;
        logic            payload_present;
        logic            last_of_item;
    } t_frame_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             i_char_code = 8'h00;
    logic                   i_end_of_frame = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   o_result_type;
    logic [7:0]             o_data_byte;
    logic [1:0]             o_command_code;
    logic signed [ID_W-1:0] o_frame_id;
    logic                   o_frame_valid;
    logic                   o_payload_present;
    logic                   o_last;

    t_frame_char   char_send_q[$];
    t_frame_result parsed_q[$];
    logic [7:0]    frame_buf[$];
    t_frame_char   next_char;

    // parser state mirror
    int              frame_pos = 0;
    logic [23:0]     cmd_chars = '0;
    logic [ID_W-1:0] id_acc = '0;
    logic            saw_start = 1'b0;
    logic            saw_end = 1'b0;
    logic            saw_sep = 1'b0;
    logic [3:0]      hi_nib = '0;
    logic            hi_ok = 1'b0;

    int   chars_accepted = 0;
    int   mismatches = 0;
    int   send_idle_pct;
    int   rx_stall_pct;
    logic hold_rx = 1'b0;

    command_frame_parser_hex_decoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_char_code       (i_char_code),
        .i_end_of_frame    (i_end_of_frame),
        .empty             (empty),
        .pop               (pop),
        .o_result_type     (o_result_type),
        .o_data_byte       (o_data_byte),
        .o_command_code    (o_command_code),
        .o_frame_id        (o_frame_id),
        .o_frame_valid     (o_frame_valid),
        .o_payload_present (o_payload_present),
        .o_last            (o_last)
    );

    always #1 i_clk = ~i_clk;

    // idle phases: none, sender, receiver, both
    always_comb begin
        case ((chars_accepted / 75) % 4)
            1: begin
                send_idle_pct = 46;
                rx_stall_pct  = 0;
            end
            2: begin
                send_idle_pct = 0;
                rx_stall_pct  = 46;
            end
            3: begin
                send_idle_pct = 23;
                rx_stall_pct  = 23;
            end
            default: begin
                send_idle_pct = 0;
                rx_stall_pct  = 0;
            end
        endcase
    end

    function automatic void hex_nibble(input logic [7:0] c, output logic [3:0] v,
                                       output logic ok);
        ok = 1'b1;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 10);
        end else if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 10);
        end else begin
            v  = 4'h0;
            ok = 1'b0;
        end
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic eof);
        logic [3:0]    nib;
        logic          nib_ok;
        logic [31:0]   weight;
        logic [31:0]   term;
        logic          got_byte;
        t_frame_result byte_res;
        t_frame_result sum_res;
        got_byte = 1'b0;
        byte_res = '0;
        if (frame_pos < MAX_FRAME) begin
            if (c == CHAR_START) saw_start = 1'b1;
            if (c == CHAR_END) saw_end = 1'b1;
            if (c == CHAR_SEP && frame_pos >= 9) saw_sep = 1'b1;
            if (frame_pos >= 1 && frame_pos <= 3) begin
                cmd_chars = cmd_chars | (24'(c) << (8 * (3 - frame_pos)));
            end
            if (frame_pos >= 5 && frame_pos <= 8) begin
                case (frame_pos)
                    5: weight = 32'd1000;
                    6: weight = 32'd100;
                    7: weight = 32'd10;
                    default: weight = 32'd1;
                endcase
                term   = (32'(c) - 32'd48) * weight;
                id_acc = id_acc + term[ID_W-1:0];
            end
            if (frame_pos >= 9) begin
                hex_nibble(c, nib, nib_ok);
                if (((frame_pos - 9) % 2) == 0) begin
                    hi_nib = nib;
                    hi_ok  = nib_ok;
                end else begin
                    byte_res.is_summary = RES_BYTE;
                    if (!hi_ok) begin
                        byte_res.data_byte = 8'h00;
                    end else if (!nib_ok) begin
                        byte_res.data_byte = {4'h0, hi_nib};
                    end else begin
                        byte_res.data_byte = {hi_nib, nib};
                    end
                    got_byte = 1'b1;
                    hi_nib   = 4'h0;
                    hi_ok    = 1'b0;
                end
            end
            frame_pos++;
        end
        if (got_byte) begin
            byte_res.last_of_item = !eof;
            parsed_q.push_back(byte_res);
        end
        if (eof) begin
            sum_res = '0;
            sum_res.is_summary = RES_SUMMARY;
            if (cmd_chars == CMD_ADD_CHARS) begin
                sum_res.command_code = CMD_ADD;
            end else if (cmd_chars == CMD_DEL_CHARS) begin
                sum_res.command_code = CMD_DEL;
            end else begin
                sum_res.command_code = CMD_NONE;
            end
            sum_res.frame_id        = id_acc;
            sum_res.frame_valid     = saw_start && saw_end;
            sum_res.payload_present = saw_sep;
            sum_res.last_of_item    = 1'b1;
            parsed_q.push_back(sum_res);
            frame_pos = 0;
            cmd_chars = '0;
            id_acc    = '0;
            saw_start = 1'b0;
            saw_end   = 1'b0;
            saw_sep   = 1'b0;
            hi_nib    = 4'h0;
            hi_ok     = 1'b0;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        t_frame_result want;
        if (parsed_q.size() == 0) begin
            $display("%0t unexpected result: expected none, got type %0b byte %0h",
                     $time, o_result_type, o_data_byte);
            mismatches++;
        end else begin
            want = parsed_q.pop_front();
            compare_field("result_type", 32'(want.is_summary), 32'(o_result_type));
            compare_field("data_byte", 32'(want.data_byte), 32'(o_data_byte));
            compare_field("command_code", 32'(want.command_code), 32'(o_command_code));
            compare_field("frame_id", 32'(want.frame_id), 32'(o_frame_id[ID_W-1:0]));
            compare_field("frame_valid", 32'(want.frame_valid), 32'(o_frame_valid));
            compare_field("payload_present", 32'(want.payload_present),
                          32'(o_payload_present));
            compare_field("last", 32'(want.last_of_item), 32'(o_last));
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push           <= 1'b0;
            i_char_code    <= 8'h00;
            i_end_of_frame <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_char(i_char_code, i_end_of_frame);
                chars_accepted <= chars_accepted + 1;
            end
            if (!push || !full) begin
                if (char_send_q.size() > 0 &&
                    (hold_rx || $urandom_range(99) >= send_idle_pct)) begin
                    next_char      = char_send_q.pop_front();
                    push           <= 1'b1;
                    i_char_code    <= next_char.ch;
                    i_end_of_frame <= next_char.eof;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_result();
            pop <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off while characters keep coming
    initial begin
        wait (chars_accepted >= 300);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 10) return 8'h30 + v;
        if ($urandom_range(1)) return 8'h41 + v - 10;
        return 8'h61 + v - 10;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
    endtask

    task automatic send_frame();
        t_frame_char fc;
        foreach (frame_buf[i]) begin
            fc.ch  = frame_buf[i];
            fc.eof = (i == frame_buf.size() - 1);
            char_send_q.push_back(fc);
        end
        frame_buf.delete();
    endtask

    initial begin
        int rand_chars;
        int keep;
        bit long_sent;
        rand_chars = 0;
        long_sent  = 1'b0;

        // full frame, byte and summary on the closing pair
        add_text("@ADD,9090G17zFa;#");
        send_frame();
        // short frame with extreme byte values in the ID
        frame_buf.push_back(8'hFF);
        add_text("DEL,");
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hFF);
        send_frame();
        // frame ending on its first character
        add_text("#");
        send_frame();

        // random frames up to the character budget; the over-length frame is not counted in it
        while (rand_chars < 200) begin
            keep = $urandom_range(9);
            if (keep <= 7) begin
                if ($urandom_range(7) != 0) begin
                    frame_buf.push_back(CHAR_START);
                end else begin
                    frame_buf.push_back(8'($urandom_range(255)));
                end
                case ($urandom_range(3))
                    0: add_text("ADD");
                    1: add_text("DEL");
                    default: repeat (3) frame_buf.push_back(8'($urandom_range(65, 90)));
                endcase
                frame_buf.push_back(",");
                repeat (4) begin
                    frame_buf.push_back(($urandom_range(7) == 0) ?
                                        8'($urandom_range(255)) :
                                        8'($urandom_range(48, 57)));
                end
                repeat ($urandom_range(12)) begin
                    frame_buf.push_back(($urandom_range(9) == 0) ?
                                        8'($urandom_range(255)) : rand_hex_char());
                end
                if ($urandom_range(3) != 0) frame_buf.push_back(CHAR_SEP);
                if ($urandom_range(5) != 0) frame_buf.push_back(CHAR_END);
                if (keep == 7) begin
                    keep = $urandom_range(1, frame_buf.size());
                    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
                end
            end else begin
                repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom_range(255)));
            end
            rand_chars += frame_buf.size();
            send_frame();

            if (!long_sent && rand_chars >= 100) begin
                // markers past the length limit must not count
                add_text("@ADD,1234");
                while (frame_buf.size() < MAX_FRAME + 6) begin
                    if (frame_buf.size() == MAX_FRAME + 2) begin
                        frame_buf.push_back(CHAR_SEP);
                    end else if (frame_buf.size() == MAX_FRAME + 4) begin
                        frame_buf.push_back(CHAR_END);
                    end else begin
                        frame_buf.push_back(rand_hex_char());
                    end
                end
                send_frame();
                long_sent = 1'b1;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_send_q.size() != 0 || push) @(posedge i_clk);
        while (parsed_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
